FILE: rtl/opd_pkg.sv
// Shared types for the order-preserving dedup core.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
package opd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the input item and restart the scan
        logic scan;     // issue the next store read and compare the last one
        logic finish;   // append if new, load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;  // match found or every kept entry compared
        logic out_free;   // result register can take a new result this cycle
    } status_t;

endpackage

FILE: rtl/opd_ctrl.sv
// Controller state machine for the order-preserving dedup core.
// Depends on opd_pkg for the state type and the command and status bundles.
module opd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  opd_pkg::status_t status,
    output opd_pkg::cmd_t    cmd
);
    import opd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A transfer in is only taken while idle, and always starts a scan
    a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SCAN)
        else $error("load did not start a scan");

    // Finish never fires while the result register is still held
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result loaded while output stalled");

    // Commands are exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.finish}))
        else $error("more than one command at once");
`endif

endmodule

FILE: rtl/opd_datapath.sv
// Datapath of the order-preserving dedup core: distinct-value memory,
// scan address and compare stage, kept count and result register.
// Depends on opd_pkg for the command and status bundles.
module opd_datapath #(
    parameter int MAX_DISTINCT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  opd_pkg::cmd_t      cmd,
    output opd_pkg::status_t   status,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value_out,
    output logic               first_seen,
    output logic [6:0]         distinct_count,
    output logic               overflow,
    output logic               set_end
);
    import opd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DISTINCT + 1);
    localparam int ADDR_W = $clog2(MAX_DISTINCT);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DISTINCT);

    // Distinct-value memory, one write and one registered read per cycle
    logic [31:0] store_mem [MAX_DISTINCT];

    logic [31:0]       value_reg;
    logic              last_reg;
    logic              found_reg,      found_next;
    logic              cmp_valid_reg,  cmp_valid_next;
    logic [CNT_W-1:0]  rd_idx_reg,     rd_idx_next;
    logic [31:0]       rd_data_reg;
    logic [CNT_W-1:0]  kept_count_reg, kept_count_next;

    logic              out_valid_reg,  out_valid_next;
    logic [31:0]       value_out_reg;
    logic              first_seen_reg;
    logic [6:0]        count_out_reg;
    logic              overflow_reg;
    logic              set_end_reg;

    logic              more;
    logic              match;
    logic              room;
    logic              do_write;
    logic              do_read;
    logic [CNT_W-1:0]  count_after;

    // Scan and append decisions
    assign more        = rd_idx_reg < kept_count_reg;
    assign match       = cmp_valid_reg && (rd_data_reg == value_reg);
    assign room        = kept_count_reg < CNT_MAX;
    assign do_read     = cmd.scan && more;
    assign do_write    = cmd.finish && !found_reg && room;
    assign count_after = do_write ? kept_count_reg + CNT_W'(1) : kept_count_reg;

    assign status.scan_done = found_reg || match || (!more && !cmp_valid_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // Next values of the control registers
    always_comb
    begin
        found_next      = found_reg;
        cmp_valid_next  = cmp_valid_reg;
        rd_idx_next     = rd_idx_reg;
        kept_count_next = kept_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (cmd.load)
        begin
            found_next     = 1'b0;
            cmp_valid_next = 1'b0;
            rd_idx_next    = '0;
        end
        if (cmd.scan)
        begin
            cmp_valid_next = more;
            if (more)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (match)
            begin
                found_next = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            kept_count_next = last_reg ? '0 : count_after;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            rd_idx_reg     <= '0;
            kept_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            found_reg      <= found_next;
            cmp_valid_reg  <= cmp_valid_next;
            rd_idx_reg     <= rd_idx_next;
            kept_count_reg <= kept_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the input item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[kept_count_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (do_read)
        begin
            rd_data_reg <= store_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    // Result register, held while the output is stalled
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_out_reg  <= value_reg;
            first_seen_reg <= !found_reg;
            count_out_reg  <= 7'(count_after);
            overflow_reg   <= !found_reg && !room;
            set_end_reg    <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value_out      = value_out_reg;
    assign first_seen     = first_seen_reg;
    assign distinct_count = count_out_reg;
    assign overflow       = overflow_reg;
    assign set_end        = set_end_reg;

`ifndef SYNTHESIS
    // The kept count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_MAX)
        else $error("kept count beyond store depth");

    // An overflowed result is new and reports a full store
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> first_seen && distinct_count == 7'(MAX_DISTINCT))
        else $error("overflow without full store");

    // The store empties after the last element of a set
    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && last_reg |=> kept_count_reg == '0)
        else $error("store not emptied at end of set");
`endif

endmodule

FILE: rtl/order_preserving_dedup_core.sv
// Top level of the order-preserving dedup core.
// Instantiates opd_ctrl and opd_datapath; depends on opd_pkg.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------------
//   input   | in_valid, in_stall    | value, last
//   output  | out_valid, out_stall  | value_out, first_seen, distinct_count, overflow, set_end
//
// The scan compares the item against the kept values one at a time, up to
// MAX_DISTINCT of them, and stops at a match. The next transfer in is taken
// only after the result is loaded, so the core scans one item at a time. The
// store memory's single read port, one entry a cycle, sets the scan rate.
// Reset is asynchronous, active low, and empties the store; contents of the
// memory are never read before being written. The next item is taken while
// a result waits in the output register; out_stall holds only the finish step.
module order_preserving_dedup_core #(
    parameter int MAX_DISTINCT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value_out,
    output logic               first_seen,
    output logic [6:0]         distinct_count,
    output logic               overflow,
    output logic               set_end
);
    import opd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each item
    opd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, scan and result register
    opd_datapath #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .value          (value),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value_out      (value_out),
        .first_seen     (first_seen),
        .distinct_count (distinct_count),
        .overflow       (overflow),
        .set_end        (set_end)
    );

endmodule

FILE: tb/order_preserving_dedup_core_tb.sv
`timescale 1ns / 1ps
// Testbench for order_preserving_dedup_core: directed and random sets of values,
// with the expected result of each input transfer checked field by field.
// Depends only on the core RTL (order_preserving_dedup_core and its submodules).
module order_preserving_dedup_core_tb;

    localparam int MAX_DISTINCT = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = MAX_DISTINCT + 8;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct {
        logic signed [31:0] value;
        logic               first;
        logic [6:0]         count;
        logic               ovf;
        logic               set_end;
    } dedup_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] value;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] value_out;
    logic               first_seen;
    logic [6:0]         distinct_count;
    logic               overflow;
    logic               set_end;

    // Predictor state: values kept in the current set, in first-seen order
    logic signed [31:0] kept_vals [MAX_DISTINCT];
    int                 kept_total = 0;
    dedup_result_t      expected_results [$];

    int          error_count = 0;
    int          items_sent  = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    int          hold_len    = 0;
    int          hold_seq    = 0;

    order_preserving_dedup_core #(
        .MAX_DISTINCT   (MAX_DISTINCT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value_out      (value_out),
        .first_seen     (first_seen),
        .distinct_count (distinct_count),
        .overflow       (overflow),
        .set_end        (set_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Search the kept values, append if new and room is left, clear on set end
    function automatic dedup_result_t dedup_step(logic signed [31:0] v, logic is_last);
        dedup_result_t r;
        logic          hit;
        hit = 1'b0;
        for (int i = 0; i < kept_total; i++)
        begin
            if (kept_vals[i] == v)
                hit = 1'b1;
        end
        r.value = v;
        r.first = !hit;
        r.ovf   = 1'b0;
        if (!hit)
        begin
            if (kept_total < MAX_DISTINCT)
            begin
                kept_vals[kept_total] = v;
                kept_total++;
            end
            else
                r.ovf = 1'b1;
        end
        r.count   = 7'(kept_total);
        r.set_end = is_last;
        if (is_last)
            kept_total = 0;
        return r;
    endfunction

    // Offer one item, wait for its transfer, then record its expected result
    task automatic send_item(input logic signed [31:0] v, input logic is_last);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(dedup_step(v, is_last));
        items_sent++;
    endtask

    // Send one set drawn from a small pool of values, with some full-range noise
    task automatic send_random_set(input int len, input int pool_size, input int noise_pct);
        logic signed [31:0] pool [128];
        logic signed [31:0] v;
        for (int i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(0, 15))
                0:       pool[i] = 32'sh8000_0000;
                1:       pool[i] = 32'sh7FFF_FFFF;
                2:       pool[i] = '0;
                3:       pool[i] = '1;
                default: pool[i] = $urandom;
            endcase
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                v = $urandom;
            else
                v = pool[$urandom_range(0, pool_size - 1)];
            send_item(v, i == len - 1);
        end
    endtask

    // Extremes of the value field, duplicates of them, single-item sets
    task automatic test_extremes();
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(32'shFFFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh0000_0001, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0000, 1'b1);
        send_item(32'sh5555_5555, 1'b1);
        send_item(32'shAAAA_AAAA, 1'b1);
        // the same value in the next set is new again
        send_item(32'shAAAA_AAAA, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b1);
    endtask

    // Fill the store, then new values overflow while kept ones still match
    task automatic test_store_full();
        for (int i = 0; i < MAX_DISTINCT; i++)
            send_item(32'(i * 7 - 30), 1'b0);
        send_item(32'sh1234_5678, 1'b0);
        send_item(32'sh1234_5678, 1'b0);
        send_item(32'(-30), 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh1234_5678, 1'b1);
    endtask

    // Random sets: mostly short with duplicates, some single items, a few overfilling
    task automatic test_random_sets();
        int shape;
        while (items_sent < RANDOM_ITEMS)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 4)
                send_random_set($urandom_range(MAX_DISTINCT + 2, MAX_DISTINCT + 16), 100, 10);
            else if (shape < 10)
                send_random_set(1, 1, 50);
            else
                send_random_set($urandom_range(2, 24), $urandom_range(1, 16), 10);
        end
    endtask

    // Hold the output off for a long stretch while items keep coming
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_len   <= 300;
        hold_seq   <= hold_seq + 1;
        for (int i = 0; i < 4; i++)
            send_random_set(10, 6, 20);
        tx_idle_en = 1'b1;
    endtask

    // Run at full rate on both sides to close the run
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 12; i++)
            send_random_set($urandom_range(2, 20), $urandom_range(1, 12), 10);
        in_valid <= 1'b0;
    endtask

    // Drive out_stall: long hold-offs on request, else random bursts
    initial
    begin : rx_stall_proc
        int hold_seen;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Check each output transfer against the oldest expected result
    always @(posedge clk)
    begin
        dedup_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value_out 0x%08h",
                         $time, value_out);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                compare_field("value_out", exp_r.value, value_out);
                compare_field("first_seen", exp_r.first, first_seen);
                compare_field("distinct_count", exp_r.count, distinct_count);
                compare_field("overflow", exp_r.ovf, overflow);
                compare_field("set_end", exp_r.set_end, set_end);
            end
        end
    end

    // End the run if it takes far longer than the slowest correct run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        last     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_store_full();
        test_random_sets();
        test_backpressure();
        test_full_rate();

        // Drain: wait for every expected result, then wait out the drain margin
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
